>>> src/bbe_pkg.sv
// Shared types, sizes and the reciprocal table of the edge-aware 3x3 box blur.
// No dependencies; every other file of the block imports this package.
package bbe_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W      = 8;
	localparam int CHAN_N     = 3;
	localparam int WIN_SIDE   = 3;
	localparam int WIN_N      = WIN_SIDE * WIN_SIDE;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 13;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int OROW_W = $clog2(MAX_HEIGHT);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

	localparam int SUM_W       = $clog2(WIN_N * ((1 << PIX_W) - 1) + 1);
	localparam int NUM_W       = SUM_W + 1;
	localparam int CNT_W       = $clog2(WIN_N + 1);
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W     = 18;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} bbe_pixel_t;

	typedef struct packed {
		bbe_pixel_t above;
		bbe_pixel_t middle;
	} bbe_line_t;

	typedef struct packed {
		logic valid;
		logic frame_end;
	} bbe_stage_t;

	// ceil(2^18 / (2n)): exact floor division of (2*sum + n) for sums of up to nine pixels
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			CNT_W'(1): m = RECIP_W'(131072);
			CNT_W'(2): m = RECIP_W'(65536);
			CNT_W'(3): m = RECIP_W'(43691);
			CNT_W'(4): m = RECIP_W'(32768);
			CNT_W'(6): m = RECIP_W'(21846);
			CNT_W'(9): m = RECIP_W'(14564);
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> src/bbe_line_store.sv
// Line store of the box blur: the pixels one and two rows back, one entry per column.
// Single write port, single registered read port; uses bbe_pkg.
module bbe_line_store (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [bbe_pkg::COL_W-1:0] rd_addr,
	output bbe_pkg::bbe_line_t        rd_data,
	input  logic                      wr_en,
	input  logic [bbe_pkg::COL_W-1:0] wr_addr,
	input  bbe_pkg::bbe_line_t        wr_data
);
	import bbe_pkg::*;

	bbe_line_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/bbe_lane.sv
// One color channel of the box blur: masked 3x3 sum, rounding numerator, and the
// reciprocal multiply that divides by the neighbor count. Uses bbe_pkg.
module bbe_lane (
	input  logic                                          clk,
	input  logic                                          load,
	input  logic [bbe_pkg::WIN_N-1:0][bbe_pkg::PIX_W-1:0] pix,
	input  logic [bbe_pkg::WIN_N-1:0]                     keep,
	input  logic [bbe_pkg::CNT_W-1:0]                     cnt,
	input  logic [bbe_pkg::RECIP_W-1:0]                   recip_s3,
	output logic [bbe_pkg::PIX_W-1:0]                     quot
);
	import bbe_pkg::*;

	logic [SUM_W-1:0]         sum;
	logic [NUM_W-1:0]         num;
	logic [NUM_W-1:0]         num_s3;
	logic [NUM_W+RECIP_W-1:0] prod;

	always_comb begin
		sum = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (keep[i]) begin
				sum = sum + SUM_W'(pix[i]);
			end
		end
		// 2*sum + n rounds half up once divided by 2n
		num = {sum, 1'b0} + NUM_W'(cnt);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_s3 <= num;
		end
	end

	assign prod = {{RECIP_W{1'b0}}, num_s3} * {{NUM_W{1'b0}}, recip_s3};
	assign quot = prod[RECIP_SHIFT +: PIX_W];

endmodule

>>> src/bbe_merge.sv
// Output stage of the box blur: joins the three channel quotients and the frame-end
// flag into one result and holds it until the master side takes the transfer. Uses bbe_pkg.
module bbe_merge (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  bbe_pkg::bbe_stage_t                            ctrl_s3,
	input  logic [bbe_pkg::CHAN_N-1:0][bbe_pkg::PIX_W-1:0] quot,
	output logic                                           load_ok,
	output logic                                           m_axis_tvalid,
	input  logic                                           m_axis_tready,
	output logic [bbe_pkg::CHAN_N*bbe_pkg::PIX_W-1:0]      m_axis_tdata,
	output logic                                           m_axis_tlast
);
	import bbe_pkg::*;

	logic                          valid_q;
	logic [CHAN_N*PIX_W-1:0]       data_q;
	logic                          last_q;

	assign load_ok = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			data_q <= quot;
			last_q <= ctrl_s3.frame_end;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tlast  = last_q;

endmodule

>>> src/box_blur_3x3_edge_aware_unit.sv
// Edge-aware 3x3 box blur over RGB pixels in raster order, three channel lanes.
// Throughput: one item per cycle unless stalled, set by the line store's single ports.
// Latency: the result for a pixel leaves with the item accepted width+1 transfers later,
// and is registered in stages 1, 2 and 3 and in bbe_merge on its way to the master side.
// Reset: frame position cleared, size 640x480; the line store is not cleared.
// Depends on bbe_pkg, bbe_line_store, bbe_lane and bbe_merge.
module box_blur_3x3_edge_aware_unit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// tdata: pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16]
	input  logic [bbe_pkg::CHAN_N*bbe_pkg::PIX_W-1:0] s_axis_tdata,
	// tuser: cmd (0 pixel, 1 drain tick)
	input  logic                                      s_axis_tuser,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// tdata: blur_red [7:0], blur_green [15:8], blur_blue [23:16]
	output logic [bbe_pkg::CHAN_N*bbe_pkg::PIX_W-1:0] m_axis_tdata,
	// tlast: frame_end
	output logic                                      m_axis_tlast,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [bbe_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [bbe_pkg::CFG_DATA_W-1:0]            cfg_data
);
	import bbe_pkg::*;

	// configuration and frame position
	logic [WIDTH_REG_W-1:0]  w_reg_q;
	logic [HEIGHT_REG_W-1:0] h_reg_q;
	logic [WIDTH_REG_W-1:0]  w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic [COL_W-1:0]        w_m1;
	logic [OROW_W-1:0]       h_m1;
	logic                    cfg_hit;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  ocol_q;
	logic [OROW_W-1:0] orow_q;

	logic in_done;
	logic primed;
	logic drop;
	logic take;
	logic o_last;

	logic [WIN_SIDE-1:0] rk;
	logic [WIN_SIDE-1:0] ck;
	logic [WIN_N-1:0]    keep_now;
	logic [CNT_W-1:0]    cnt_now;
	bbe_pixel_t          pix_in;

	// stage 1: line store read returns
	logic             valid_s1;
	logic [COL_W-1:0] addr_s1;
	bbe_pixel_t       data_s1;
	logic             emit_s1;
	logic [WIN_N-1:0] keep_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             last_s1;
	logic             byp_s1;
	bbe_line_t        rd_line;
	bbe_pixel_t       top_px;
	bbe_pixel_t       mid_px;
	bbe_pixel_t       wr_mid_q;
	bbe_pixel_t       wr_data_q;
	logic             s1_move;

	// stage 2: window holds the neighborhood
	bbe_pixel_t       win_q [WIN_N];
	logic             valid_s2;
	logic [WIN_N-1:0] keep_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic             last_s2;
	logic [CHAN_N-1:0][WIN_N-1:0][PIX_W-1:0] lane_pix;

	// stage 3: numerators registered in the lanes
	logic               valid_s3;
	logic               last_s3;
	logic [RECIP_W-1:0] recip_s3;
	bbe_stage_t         ctrl_s3;
	logic [CHAN_N-1:0][PIX_W-1:0] quot;

	logic load_ok;
	logic en1;
	logic en2;
	logic en3;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	always_comb begin
		if (w_reg_q == '0) begin
			w_eff = WIDTH_REG_W'(1);
		end else if (w_reg_q > WIDTH_REG_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_REG_W'(MAX_WIDTH);
		end else begin
			w_eff = w_reg_q;
		end
		if (h_reg_q == '0) begin
			h_eff = HEIGHT_REG_W'(1);
		end else if (h_reg_q > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
		end else begin
			h_eff = h_reg_q;
		end
	end

	assign w_m1 = COL_W'(w_eff - WIDTH_REG_W'(1));
	assign h_m1 = OROW_W'(h_eff - HEIGHT_REG_W'(1));

	// handshake: each stage loads when it is empty or the next one loads
	assign en3           = !valid_s3 || load_ok;
	assign en2           = !valid_s2 || en3;
	assign en1           = !valid_s1 || en2;
	assign s_axis_tready = en1;

	assign in_done = row_q >= ROW_W'(h_eff);
	assign primed  = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
	// drain ticks before the frame's last pixel change nothing
	assign drop    = s_axis_tuser && !in_done;
	assign take    = s_axis_tvalid && en1 && !drop;
	assign o_last  = (orow_q == h_m1) && (ocol_q == w_m1);

	assign pix_in.red   = s_axis_tdata[0 +: PIX_W];
	assign pix_in.green = s_axis_tdata[PIX_W +: PIX_W];
	assign pix_in.blue  = s_axis_tdata[2*PIX_W +: PIX_W];

	always_comb begin
		rk = {orow_q != h_m1, 1'b1, orow_q != '0};
		ck = {ocol_q != w_m1, 1'b1, ocol_q != '0};
		for (int r = 0; r < WIN_SIDE; r++) begin
			for (int c = 0; c < WIN_SIDE; c++) begin
				keep_now[r*WIN_SIDE + c] = rk[r] & ck[c];
			end
		end
		cnt_now = CNT_W'($countones(rk)) * CNT_W'($countones(ck));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_reg_q <= WIDTH_RESET;
			h_reg_q <= HEIGHT_RESET;
			col_q   <= '0;
			row_q   <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  w_reg_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: h_reg_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (take) begin
			if (primed && o_last) begin
				// frame finished: the next pixel starts a new frame
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (col_q == w_m1) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
				if (primed) begin
					if (ocol_q == w_m1) begin
						ocol_q <= '0;
						orow_q <= orow_q + OROW_W'(1);
					end else begin
						ocol_q <= ocol_q + COL_W'(1);
					end
				end
			end
		end
	end

	bbe_line_store u_line (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (col_q),
		.rd_data (rd_line),
		.wr_en   (s1_move),
		.wr_addr (addr_s1),
		.wr_data ({mid_px, data_s1})
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1 <= col_q;
			data_s1 <= (!s_axis_tuser && !in_done) ? pix_in : '0;
			emit_s1 <= primed;
			keep_s1 <= keep_now;
			cnt_s1  <= cnt_now;
			last_s1 <= o_last;
			// one-column frames: the item ahead writes this entry on the same edge
			byp_s1  <= valid_s1 && (addr_s1 == col_q);
		end
	end

	assign top_px  = byp_s1 ? wr_mid_q  : rd_line.above;
	assign mid_px  = byp_s1 ? wr_data_q : rd_line.middle;
	assign s1_move = valid_s1 && en2;

	always_ff @(posedge clk) begin
		if (s1_move) begin
			wr_mid_q  <= mid_px;
			wr_data_q <= data_s1;
			win_q[0]  <= win_q[1];
			win_q[1]  <= win_q[2];
			win_q[2]  <= top_px;
			win_q[3]  <= win_q[4];
			win_q[4]  <= win_q[5];
			win_q[5]  <= mid_px;
			win_q[6]  <= win_q[7];
			win_q[7]  <= win_q[8];
			win_q[8]  <= data_s1;
			keep_s2   <= keep_s1;
			cnt_s2    <= cnt_s1;
			last_s2   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			lane_pix[0][i] = win_q[i].red;
			lane_pix[1][i] = win_q[i].green;
			lane_pix[2][i] = win_q[i].blue;
		end
	end

	// stage 3 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			last_s3  <= last_s2;
			recip_s3 <= recip(cnt_s2);
		end
	end

	for (genvar g = 0; g < CHAN_N; g++) begin : g_lane
		bbe_lane u_lane (
			.clk      (clk),
			.load     (en3),
			.pix      (lane_pix[g]),
			.keep     (keep_s2),
			.cnt      (cnt_s2),
			.recip_s3 (recip_s3),
			.quot     (quot[g])
		);
	end

	assign ctrl_s3.valid     = valid_s3;
	assign ctrl_s3.frame_end = last_s3;

	bbe_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl_s3       (ctrl_s3),
		.quot          (quot),
		.load_ok       (load_ok),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
